### rtl/mck_pkg.sv
`timescale 1ns / 1ps

package mck_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned TICK_W = 16;
    localparam int unsigned PAT_W = 6;
    localparam int unsigned CNT_W = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned IN_DATA_W = 8;
    localparam int unsigned OUT_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_DOT_ON = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DASH_ON = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYM_GAP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_GAP = 2'd3;

    localparam logic [TICK_W-1:0] DOT_ON_RESET = 16'd250;
    localparam logic [TICK_W-1:0] DASH_ON_RESET = 16'd1000;
    localparam logic [TICK_W-1:0] SYM_GAP_RESET = 16'd250;
    localparam logic [TICK_W-1:0] CHAR_GAP_RESET = 16'd3000;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [PAT_W-1:0] pattern;
    } code_t;

    typedef struct packed {
        logic  is_load;
        code_t code;
    } item_t;

    typedef struct packed {
        logic accepted;
        logic busy_res;
        logic key_level;
    } result_t;

    // pattern bit 0 is the first symbol, 1 means dash
    function automatic code_t char_lookup(input logic [CHAR_W-1:0] c);
        code_t r;
        r = '{count: 3'd0, pattern: 6'b000000};
        case (c)
            8'h41: r = '{count: 3'd2, pattern: 6'b000010};
            8'h42: r = '{count: 3'd4, pattern: 6'b000001};
            8'h43: r = '{count: 3'd4, pattern: 6'b000101};
            8'h44: r = '{count: 3'd3, pattern: 6'b000001};
            8'h45: r = '{count: 3'd1, pattern: 6'b000000};
            8'h46: r = '{count: 3'd4, pattern: 6'b000100};
            8'h47: r = '{count: 3'd3, pattern: 6'b000011};
            8'h48: r = '{count: 3'd4, pattern: 6'b000000};
            8'h49: r = '{count: 3'd2, pattern: 6'b000000};
            8'h4A: r = '{count: 3'd4, pattern: 6'b001110};
            8'h4B: r = '{count: 3'd3, pattern: 6'b000101};
            8'h4C: r = '{count: 3'd4, pattern: 6'b000010};
            8'h4D: r = '{count: 3'd2, pattern: 6'b000011};
            8'h4E: r = '{count: 3'd2, pattern: 6'b000001};
            8'h4F: r = '{count: 3'd3, pattern: 6'b000111};
            8'h50: r = '{count: 3'd4, pattern: 6'b000110};
            8'h51: r = '{count: 3'd4, pattern: 6'b001011};
            8'h52: r = '{count: 3'd3, pattern: 6'b000010};
            8'h53: r = '{count: 3'd3, pattern: 6'b000000};
            8'h54: r = '{count: 3'd1, pattern: 6'b000001};
            8'h55: r = '{count: 3'd3, pattern: 6'b000100};
            8'h56: r = '{count: 3'd4, pattern: 6'b001000};
            8'h57: r = '{count: 3'd3, pattern: 6'b000110};
            8'h58: r = '{count: 3'd4, pattern: 6'b001001};
            8'h59: r = '{count: 3'd4, pattern: 6'b001101};
            8'h5A: r = '{count: 3'd4, pattern: 6'b000011};
            8'h31: r = '{count: 3'd5, pattern: 6'b011110};
            8'h32: r = '{count: 3'd5, pattern: 6'b011100};
            8'h33: r = '{count: 3'd5, pattern: 6'b011000};
            8'h34: r = '{count: 3'd5, pattern: 6'b010000};
            8'h35: r = '{count: 3'd5, pattern: 6'b000000};
            8'h36: r = '{count: 3'd5, pattern: 6'b000001};
            8'h37: r = '{count: 3'd5, pattern: 6'b000011};
            8'h38: r = '{count: 3'd5, pattern: 6'b000111};
            8'h39: r = '{count: 3'd5, pattern: 6'b001111};
            8'h30: r = '{count: 3'd5, pattern: 6'b011111};
            8'h3F: r = '{count: 3'd6, pattern: 6'b001100};
            8'h2F: r = '{count: 3'd5, pattern: 6'b001001};
            8'h28: r = '{count: 3'd5, pattern: 6'b001101};
            8'h29: r = '{count: 3'd6, pattern: 6'b101101};
            8'h2D: r = '{count: 3'd6, pattern: 6'b100001};
            8'h2E: r = '{count: 3'd6, pattern: 6'b101010};
            default: r = '{count: 3'd0, pattern: 6'b000000};
        endcase
        return r;
    endfunction

endpackage

### rtl/mck_front.sv
`timescale 1ns / 1ps

module mck_front
(
    input  logic                        op,
    input  logic [mck_pkg::CHAR_W-1:0]  char_code,
    output mck_pkg::item_t              item
);

    always_comb
    begin
        item.is_load = op;
        item.code    = mck_pkg::char_lookup(char_code);
    end

endmodule

### rtl/mck_queue.sv
`timescale 1ns / 1ps

module mck_queue
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mck_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output mck_pkg::item_t  head_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    mck_pkg::item_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/mck_back.sv
`timescale 1ns / 1ps

module mck_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mck_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mck_pkg::TICK_W-1:0]      cfg_data,
    input  logic                            item_valid,
    input  mck_pkg::item_t                  item,
    output logic                            pop,
    output logic                            res_valid,
    output mck_pkg::result_t                res,
    input  logic                            res_ready
);

    typedef enum logic [1:0]
    {
        PH_IDLE    = 2'd0,
        PH_ON      = 2'd1,
        PH_SYMGAP  = 2'd2,
        PH_CHARGAP = 2'd3
    } phase_t;

    logic [mck_pkg::TICK_W-1:0] dot_on_reg;
    logic [mck_pkg::TICK_W-1:0] dash_on_reg;
    logic [mck_pkg::TICK_W-1:0] sym_gap_reg;
    logic [mck_pkg::TICK_W-1:0] char_gap_reg;

    phase_t                     phase_reg;
    phase_t                     phase_next;
    logic [mck_pkg::PAT_W-1:0]  pattern_reg;
    logic [mck_pkg::PAT_W-1:0]  pattern_next;
    logic [mck_pkg::CNT_W-1:0]  left_reg;
    logic [mck_pkg::CNT_W-1:0]  left_next;
    logic [mck_pkg::TICK_W-1:0] timer_reg;
    logic [mck_pkg::TICK_W-1:0] timer_next;
    logic                       res_valid_reg;
    logic                       res_valid_next;
    mck_pkg::result_t           res_reg;
    mck_pkg::result_t           res_next;

    logic [mck_pkg::PAT_W-1:0]  shifted_pattern;
    logic [mck_pkg::CNT_W-1:0]  dec_left;

    assign pop       = item_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign shifted_pattern = pattern_reg >> 1;
    assign dec_left        = (left_reg != '0) ? left_reg - 1'b1 : '0;

    always_comb
    begin
        phase_next     = phase_reg;
        pattern_next   = pattern_reg;
        left_next      = left_reg;
        timer_next     = timer_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_ready;
        if (pop)
        begin
            res_valid_next = 1'b1;
            if (item.is_load)
            begin
                res_next.accepted = 1'b0;
                if (phase_reg == PH_IDLE)
                begin
                    pattern_next      = item.code.pattern;
                    left_next         = item.code.count;
                    res_next.accepted = 1'b1;
                    if (item.code.count != '0)
                    begin
                        phase_next = PH_ON;
                        timer_next = item.code.pattern[0] ? dash_on_reg : dot_on_reg;
                    end
                    else
                    begin
                        phase_next = PH_CHARGAP;
                        timer_next = char_gap_reg;
                    end
                end
                res_next.key_level = (phase_next == PH_ON);
                res_next.busy_res  = (phase_next != PH_IDLE);
            end
            else
            begin
                res_next.key_level = (phase_reg == PH_ON);
                res_next.busy_res  = (phase_reg != PH_IDLE);
                res_next.accepted  = 1'b0;
                if (phase_reg != PH_IDLE)
                begin
                    if (timer_reg > 16'd1)
                    begin
                        timer_next = timer_reg - 1'b1;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_ON:
                            begin
                                phase_next = PH_SYMGAP;
                                timer_next = sym_gap_reg;
                            end
                            PH_SYMGAP:
                            begin
                                left_next    = dec_left;
                                pattern_next = shifted_pattern;
                                if (dec_left != '0)
                                begin
                                    phase_next = PH_ON;
                                    timer_next = shifted_pattern[0] ? dash_on_reg : dot_on_reg;
                                end
                                else
                                begin
                                    phase_next = PH_CHARGAP;
                                    timer_next = char_gap_reg;
                                end
                            end
                            default:
                            begin
                                phase_next   = PH_IDLE;
                                timer_next   = '0;
                                pattern_next = '0;
                                left_next    = '0;
                            end
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            pattern_reg   <= '0;
            left_reg      <= '0;
            timer_reg     <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pattern_reg   <= pattern_next;
            left_reg      <= left_next;
            timer_reg     <= timer_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_on_reg   <= mck_pkg::DOT_ON_RESET;
            dash_on_reg  <= mck_pkg::DASH_ON_RESET;
            sym_gap_reg  <= mck_pkg::SYM_GAP_RESET;
            char_gap_reg <= mck_pkg::CHAR_GAP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mck_pkg::CFG_DOT_ON:   dot_on_reg   <= cfg_data;
                mck_pkg::CFG_DASH_ON:  dash_on_reg  <= cfg_data;
                mck_pkg::CFG_SYM_GAP:  sym_gap_reg  <= cfg_data;
                mck_pkg::CFG_CHAR_GAP: char_gap_reg <= cfg_data;
                default:               dot_on_reg   <= dot_on_reg;
            endcase
        end
    end

endmodule

### rtl/morse_code_keyer.sv
`timescale 1ns / 1ps

// Morse keyer: each input item is a time tick (tuser 0) or a character load (tuser 1) and gives
// exactly one result item with the key level, busy flag and load-accepted flag. The front end
// decodes the character through a constant table, a small queue holds decoded items, and the
// back end runs the on / symbol gap / character gap timer one item per cycle, so the block
// sustains one item per clock unless the output stalls, and the queue depth sets how many items
// can be absorbed while the output is stalled. The user must write timing registers through the
// cfg port only while no item is in flight; the block itself does not enforce this.

module morse_code_keyer
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mck_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mck_pkg::TICK_W-1:0]          cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mck_pkg::IN_DATA_W-1:0]       s_tdata,    // char_code
    input  logic                                s_tuser,    // op
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mck_pkg::OUT_DATA_W-1:0]      m_tdata     // key_level, busy_res, accepted, zeros
);

    mck_pkg::item_t   front_item;
    mck_pkg::item_t   head_item;
    mck_pkg::result_t res;
    logic             queue_full;
    logic             queue_not_empty;
    logic             pop;

    assign s_tready = !queue_full;
    assign m_tdata  = {{(mck_pkg::OUT_DATA_W - 3){1'b0}}, res.accepted, res.busy_res,
                       res.key_level};

    mck_front u_front
    (
        .op        (s_tuser),
        .char_code (s_tdata[mck_pkg::CHAR_W-1:0]),
        .item      (front_item)
    );

    mck_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid && !queue_full),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .head_item (head_item)
    );

    mck_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (queue_not_empty),
        .item       (head_item),
        .pop        (pop),
        .res_valid  (m_tvalid),
        .res        (res),
        .res_ready  (m_tready)
    );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned CYCLE_LIMIT = 10_000_000;

    typedef enum logic [1:0] {KEY_IDLE, KEY_ON, KEY_SYM_GAP, KEY_CHAR_GAP} key_phase_t;
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_BEAT} rx_mode_t;

    typedef struct packed {
        logic       is_load;
        logic [7:0] ch;
    } stim_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_we = 1'b0;
    logic [mck_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [mck_pkg::TICK_W-1:0]        cfg_data = '0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [mck_pkg::IN_DATA_W-1:0]     s_tdata = '0;
    logic                              s_tuser = 1'b0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [mck_pkg::OUT_DATA_W-1:0]    m_tdata;

    // keyer timing and state as predicted
    logic [15:0]      t_dot, t_dash, t_sgap, t_cgap;
    key_phase_t       kr_phase;
    logic [15:0]      kr_timer;
    logic [5:0]       kr_pat;
    logic [2:0]       kr_left;

    stim_t            pending[$];
    mck_pkg::result_t keyed_out[$];
    stim_t            nxt;
    mck_pkg::result_t want, got;

    int               fed, taken, checked, errors;
    int               loads_taken, loads_refused, keyed_ticks;
    int unsigned      cycles;
    int               burst_left, gap_left;
    rx_mode_t         stall_mode;
    int               stall_left;
    logic [2:0]       stall_phase;

    string            glyphs = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789?/()-.";
    logic [7:0]       probe [10] = '{"(", ")", "?", "0", ".", "-", "a", "Z", 8'h00, 8'hFF};

    morse_code_keyer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void morse_of(input logic [7:0] c, output logic [5:0] pat,
                                     output logic [2:0] cnt);
        string code;
        case (c)
            "A": code = ".-";     "B": code = "-...";   "C": code = "-.-.";
            "D": code = "-..";    "E": code = ".";      "F": code = "..-.";
            "G": code = "--.";    "H": code = "....";   "I": code = "..";
            "J": code = ".---";   "K": code = "-.-";    "L": code = ".-..";
            "M": code = "--";     "N": code = "-.";     "O": code = "---";
            "P": code = ".--.";   "Q": code = "--.-";   "R": code = ".-.";
            "S": code = "...";    "T": code = "-";      "U": code = "..-";
            "V": code = "...-";   "W": code = ".--";    "X": code = "-..-";
            "Y": code = "-.--";   "Z": code = "--..";
            "1": code = ".----";  "2": code = "..---";  "3": code = "...--";
            "4": code = "....-";  "5": code = ".....";  "6": code = "-....";
            "7": code = "--...";  "8": code = "---..";  "9": code = "----.";
            "0": code = "-----";
            "?": code = "..--.."; "/": code = "-..-.";  "(": code = "-.--.";
            ")": code = "-.--.-"; "-": code = "-....-"; ".": code = ".-.-.-";
            default: code = "";
        endcase
        pat = '0;
        for (int i = 0; i < code.len(); i++)
            if (code[i] == "-")
                pat[i] = 1'b1;
        cnt = 3'(code.len());
    endfunction

    function automatic mck_pkg::result_t keyer_step(input logic is_load, input logic [7:0] ch);
        mck_pkg::result_t r;
        logic [5:0]       pat;
        logic [2:0]       cnt;
        r = '0;
        if (is_load)
        begin
            if (kr_phase == KEY_IDLE)
            begin
                morse_of(ch, pat, cnt);
                kr_pat = pat;
                kr_left = cnt;
                if (cnt != 0)
                begin
                    kr_phase = KEY_ON;
                    kr_timer = pat[0] ? t_dash : t_dot;
                end
                else
                begin
                    kr_phase = KEY_CHAR_GAP;
                    kr_timer = t_cgap;
                end
                r.accepted = 1'b1;
                loads_taken++;
            end
            else
                loads_refused++;
            r.key_level = (kr_phase == KEY_ON);
            r.busy_res = (kr_phase != KEY_IDLE);
            return r;
        end
        r.key_level = (kr_phase == KEY_ON);
        r.busy_res = (kr_phase != KEY_IDLE);
        if (r.key_level)
            keyed_ticks++;
        if (kr_phase != KEY_IDLE)
        begin
            if (kr_timer > 1)
                kr_timer = kr_timer - 1'b1;
            else
                case (kr_phase)
                    KEY_ON:
                    begin
                        kr_phase = KEY_SYM_GAP;
                        kr_timer = t_sgap;
                    end
                    KEY_SYM_GAP:
                    begin
                        if (kr_left != 0)
                            kr_left = kr_left - 1'b1;
                        kr_pat = kr_pat >> 1;
                        if (kr_left != 0)
                        begin
                            kr_phase = KEY_ON;
                            kr_timer = kr_pat[0] ? t_dash : t_dot;
                        end
                        else
                        begin
                            kr_phase = KEY_CHAR_GAP;
                            kr_timer = t_cgap;
                        end
                    end
                    default:
                    begin
                        kr_phase = KEY_IDLE;
                        kr_timer = '0;
                        kr_pat = '0;
                        kr_left = '0;
                    end
                endcase
        end
        return r;
    endfunction

    task automatic queue_item(input logic is_load, input logic [7:0] ch);
        pending.push_back('{is_load: is_load, ch: ch});
        fed++;
    endtask

    task automatic wait_quiet();
        do
            @(posedge clk);
        while (taken != fed || keyed_out.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [mck_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            mck_pkg::CFG_DOT_ON:  t_dot = val;
            mck_pkg::CFG_DASH_ON: t_dash = val;
            mck_pkg::CFG_SYM_GAP: t_sgap = val;
            default:              t_cgap = val;
        endcase
    endtask

    task automatic set_timing(input logic [15:0] dot, input logic [15:0] dash,
                              input logic [15:0] sgap, input logic [15:0] cgap);
        write_reg(mck_pkg::CFG_DOT_ON, dot);
        write_reg(mck_pkg::CFG_DASH_ON, dash);
        write_reg(mck_pkg::CFG_SYM_GAP, sgap);
        write_reg(mck_pkg::CFG_CHAR_GAP, cgap);
        cfg_we <= 1'b0;
    endtask

    // tick until the predicted keyer is back to idle
    task automatic run_out();
        int n;
        wait_quiet();
        while (kr_phase != KEY_IDLE)
        begin
            n = (kr_timer == 0) ? 1 : kr_timer;
            repeat (n) queue_item(1'b0, 8'($urandom));
            wait_quiet();
        end
    endtask

    task automatic random_words(input int n_items);
        int         goal, span, n_ticks, pick;
        logic [7:0] c;
        logic [5:0] pat;
        logic [2:0] cnt;
        goal = fed + n_items;
        while (fed < goal)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                c = glyphs[$urandom_range(0, glyphs.len() - 1)];
            else if (pick < 9)
                c = 8'($urandom);
            else
                c = 8'($urandom_range(8'h61, 8'h7A));
            morse_of(c, pat, cnt);
            span = (t_cgap == 0) ? 1 : t_cgap;
            for (int k = 0; k < cnt; k++)
                span += (pat[k] ? ((t_dash == 0) ? 1 : t_dash) : ((t_dot == 0) ? 1 : t_dot))
                        + ((t_sgap == 0) ? 1 : t_sgap);
            if ($urandom_range(0, 3) != 0)
                n_ticks = span + $urandom_range(0, 3);
            else
                n_ticks = $urandom_range(0, span);
            queue_item(1'b1, c);
            for (int k = 0; k < n_ticks; k++)
            begin
                if ($urandom_range(0, 15) == 0)
                    queue_item(1'b1, 8'($urandom));
                queue_item(1'b0, 8'($urandom));
            end
        end
    endtask

    // sender: bursts of items with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tuser <= 1'b0;
            s_tdata <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left != 0)
            begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending.size() != 0)
            begin
                nxt = pending.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= nxt.is_load;
                s_tdata <= nxt.ch;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_mode <= RX_OPEN;
            stall_left <= 0;
            stall_phase <= '0;
        end
        else
        begin
            stall_phase <= stall_phase + 1'b1;
            if (stall_left == 0)
            begin
                stall_mode <= rx_mode_t'($urandom_range(0, 3));
                stall_left <= $urandom_range(16, 400);
            end
            else
                stall_left <= stall_left - 1;
            case (stall_mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                RX_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
                default:   m_tready <= (stall_phase < 3'd3);
            endcase
        end
    end

    // predict on each accepted item, check each result item
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            keyed_out.push_back(keyer_step(s_tuser, s_tdata));
            taken++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            checked++;
            if (keyed_out.size() == 0)
            begin
                $display("%0t: result %h with nothing expected", $time, m_tdata);
                errors++;
            end
            else
            begin
                want = keyed_out.pop_front();
                got = m_tdata[2:0];
                if (got !== want)
                begin
                    $display("%0t: expected key %b busy %b acc %b, got key %b busy %b acc %b",
                             $time, want.key_level, want.busy_res, want.accepted,
                             got.key_level, got.busy_res, got.accepted);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial
    begin
        t_dot = 16'd250;
        t_dash = 16'd1000;
        t_sgap = 16'd250;
        t_cgap = 16'd3000;
        kr_phase = KEY_IDLE;
        kr_timer = '0;
        kr_pat = '0;
        kr_left = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // idle ticks, a load at reset timing, loads refused while busy
        queue_item(1'b0, 8'h00);
        queue_item(1'b0, 8'hFF);
        queue_item(1'b1, "E");
        queue_item(1'b1, "T");
        queue_item(1'b0, 8'h55);
        queue_item(1'b1, "Q");
        wait_quiet();
        // new timing lands mid-character
        set_timing(16'd1, 16'd1, 16'd1, 16'd1);
        run_out();

        foreach (probe[i])
        begin
            queue_item(1'b1, probe[i]);
            queue_item(1'b1, "E");
            run_out();
        end

        set_timing(16'd0, 16'd0, 16'd0, 16'd0);
        queue_item(1'b1, ".");
        run_out();

        for (int p = 0; p < 5; p++)
        begin
            wait_quiet();
            case (p)
                0: set_timing(16'd1, 16'd1, 16'd1, 16'd1);
                1: set_timing(16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
                              16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)));
                2: set_timing(16'd0, 16'd2, 16'd0, 16'd3);
                3: set_timing(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                              16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)));
                default: set_timing(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                                    16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)));
            endcase
            random_words(20);
        end

        // full-scale timers, left running at the end
        run_out();
        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_item(1'b1, "T");
        repeat (24) queue_item(1'b0, 8'($urandom));
        queue_item(1'b1, "E");
        queue_item(1'b0, 8'($urandom));
        wait_quiet();

        repeat (16) @(posedge clk);
        $display("ran %0d items: %0d loads taken, %0d refused, %0d keyed ticks, %0d results",
                 taken, loads_taken, loads_refused, keyed_ticks, checked);
        $display("timing ran from zero and one tick up to full-scale timers");
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
